>>> rtl/lmss_pkg.sv
`timescale 1ns / 1ps

package lmss_pkg;

  // Opcode carried in the input beat's tuser
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Colour planes
  localparam logic COLOR_RED   = 1'b0;
  localparam logic COLOR_GREEN = 1'b1;

  // Configuration register indexes
  localparam int  CFG_IDX_W       = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_DWELL   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN_DWELL = 1'b1;

  // Fixed field widths
  localparam int DWELL_W   = 16;
  localparam int ROW_IN_W  = 4;
  localparam int COL_IN_W  = 4;
  localparam int BYTE_W    = 8;
  localparam int IN_DATA_W = 16;
  localparam int IN_USER_W = 2;
  localparam int OUT_DATA_W = 16;
  localparam int OUT_FIELDS = 9;

  localparam logic [DWELL_W-1:0] DWELL_RESET = 16'd100;

  typedef enum logic [1:0] {
    PH_ROWSEL,
    PH_SHIFT,
    PH_LATCH,
    PH_DWELL
  } phase_t;

  // What one beat turns into, ahead of the frame store read data
  typedef struct packed {
    logic       shift;
    logic       color;
    logic [2:0] bit_sel;
    logic       column_shift;
    logic       row_data;
    logic       row_shift;
    logic       latch;
    logic       enable;
  } tick_t;

endpackage

>>> rtl/lmss_frame_store.sv
`timescale 1ns / 1ps

module lmss_frame_store #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  logic                        wr_lower,
  input  logic [AW-1:0]               wr_addr,
  input  logic [lmss_pkg::BYTE_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [lmss_pkg::BYTE_W-1:0] rd_upper,
  output logic [lmss_pkg::BYTE_W-1:0] rd_lower,
  output logic                        clearing
);

  // Two byte lanes: upper half of the row and lower half, same word address
  logic [lmss_pkg::BYTE_W-1:0] mem_upper [DEPTH];
  logic [lmss_pkg::BYTE_W-1:0] mem_lower [DEPTH];

  logic                        clearing_r;
  logic [AW-1:0]               clr_addr_r;
  logic [lmss_pkg::BYTE_W-1:0] rd_upper_r;
  logic [lmss_pkg::BYTE_W-1:0] rd_lower_r;

  assign clearing = clearing_r;
  assign rd_upper = rd_upper_r;
  assign rd_lower = rd_lower_r;

  // Sweep zeros through every word after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clearing_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem_upper[clr_addr_r] <= '0;
      mem_lower[clr_addr_r] <= '0;
    end else if (wr_en) begin
      if (wr_lower) begin
        mem_lower[wr_addr] <= wr_data;
      end else begin
        mem_upper[wr_addr] <= wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_upper_r <= mem_upper[rd_addr];
      rd_lower_r <= mem_lower[rd_addr];
    end
  end

endmodule

>>> rtl/lmss_scan_ctrl.sv
`timescale 1ns / 1ps

module lmss_scan_ctrl #(
  parameter int ROWS          = 16,
  parameter int BYTES_PER_ROW = 16,
  parameter int AW            = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                tick,
  input  logic                                cfg_we,
  input  logic [lmss_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [lmss_pkg::DWELL_W-1:0]        cfg_wdata,
  output lmss_pkg::tick_t                     info,
  output logic                                dwell_active,
  output logic [AW-1:0]                       rd_addr
);

  localparam int HALF        = BYTES_PER_ROW / 2;
  localparam int SHIFT_TICKS = HALF * 8;
  localparam int MAXC        = (ROWS > SHIFT_TICKS) ? ROWS : SHIFT_TICKS;
  localparam int BC_W        = $clog2(MAXC + 1);
  localparam int ROW_W       = $clog2(ROWS);

  localparam logic [BC_W-1:0]  SHIFT_END = BC_W'(SHIFT_TICKS);
  localparam logic [BC_W-1:0]  ROWS_END  = BC_W'(ROWS);
  localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(ROWS - 1);

  logic [ROW_W-1:0]             row_r, row_nxt;
  lmss_pkg::phase_t             phase_r, phase_nxt;
  logic [BC_W-1:0]              bc_r, bc_nxt;
  logic                         color_r, color_nxt;
  logic [lmss_pkg::DWELL_W-1:0] dwell_r, dwell_nxt;
  logic [lmss_pkg::DWELL_W-1:0] red_dwell_r, green_dwell_r;

  logic [lmss_pkg::DWELL_W-1:0] load;
  logic [lmss_pkg::DWELL_W-1:0] dec;
  logic [BC_W-1:0]              inc;
  logic [BC_W-1:0]              bc_eff;
  logic                         do_rowsel;
  logic                         seg_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_dwell_r   <= lmss_pkg::DWELL_RESET;
      green_dwell_r <= lmss_pkg::DWELL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        lmss_pkg::CFG_RED_DWELL:   red_dwell_r   <= cfg_wdata;
        lmss_pkg::CFG_GREEN_DWELL: green_dwell_r <= cfg_wdata;
        default:                   red_dwell_r   <= red_dwell_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r   <= '0;
      phase_r <= lmss_pkg::PH_ROWSEL;
      bc_r    <= '0;
      color_r <= lmss_pkg::COLOR_RED;
      dwell_r <= '0;
    end else begin
      row_r   <= row_nxt;
      phase_r <= phase_nxt;
      bc_r    <= bc_nxt;
      color_r <= color_nxt;
      dwell_r <= dwell_nxt;
    end
  end

  // Word holds both halves of the row: address by colour, row and byte pair
  assign rd_addr = AW'((int'(color_r) * ROWS + int'(row_r)) * HALF + int'(bc_r >> 3));

  assign dwell_active = (phase_r == lmss_pkg::PH_DWELL) && (dwell_r != '0);

  always_comb begin
    row_nxt   = row_r;
    phase_nxt = phase_r;
    bc_nxt    = bc_r;
    color_nxt = color_r;
    dwell_nxt = dwell_r;
    info      = '0;
    info.color   = color_r;
    info.bit_sel = ~bc_r[2:0];
    load      = color_r ? green_dwell_r : red_dwell_r;
    dec       = dwell_r - 1'b1;
    do_rowsel = 1'b0;
    seg_end   = 1'b0;
    inc       = bc_r + 1'b1;
    bc_eff    = '0;

    if (tick) begin
      unique case (phase_r)
        lmss_pkg::PH_SHIFT: begin
          info.shift        = 1'b1;
          info.column_shift = 1'b1;
          if (inc >= SHIFT_END) begin
            bc_nxt    = '0;
            phase_nxt = lmss_pkg::PH_LATCH;
          end else begin
            bc_nxt = inc;
          end
        end
        lmss_pkg::PH_LATCH: begin
          info.latch = 1'b1;
          dwell_nxt  = load;
          if (load == '0) begin
            seg_end = 1'b1;
          end else begin
            phase_nxt = lmss_pkg::PH_DWELL;
          end
        end
        lmss_pkg::PH_DWELL: begin
          if (dwell_r != '0) begin
            info.enable = 1'b1;
            dwell_nxt   = dec;
            seg_end     = (dec == '0);
          end else begin
            do_rowsel = 1'b1;
          end
        end
        lmss_pkg::PH_ROWSEL: begin
          do_rowsel = 1'b1;
        end
        default: begin
          do_rowsel = 1'b1;
        end
      endcase

      // Row select: a one only at position ROWS-1-row
      if (do_rowsel) begin
        bc_eff = ((phase_r == lmss_pkg::PH_ROWSEL) && (bc_r < ROWS_END)) ? bc_r : '0;
        inc    = bc_eff + 1'b1;
        info.row_shift = 1'b1;
        info.row_data  = (bc_eff == (BC_W'(ROWS - 1) - BC_W'(row_r)));
        if (inc >= ROWS_END) begin
          bc_nxt    = '0;
          color_nxt = lmss_pkg::COLOR_RED;
          phase_nxt = lmss_pkg::PH_SHIFT;
        end else begin
          bc_nxt    = inc;
          phase_nxt = lmss_pkg::PH_ROWSEL;
        end
      end

      // Red done: go to green; green done: advance the row
      if (seg_end) begin
        bc_nxt = '0;
        if (color_r == lmss_pkg::COLOR_RED) begin
          color_nxt = lmss_pkg::COLOR_GREEN;
          phase_nxt = lmss_pkg::PH_SHIFT;
        end else begin
          color_nxt = lmss_pkg::COLOR_RED;
          row_nxt   = (row_r == ROW_LAST) ? '0 : row_r + 1'b1;
          phase_nxt = lmss_pkg::PH_ROWSEL;
        end
      end
    end
  end

endmodule

>>> rtl/led_matrix_scan_sequencer_unit.sv
`timescale 1ns / 1ps
// Path: an input beat that is taken passes through stage 1 and then the output register as a result beat.
// Throughput: one beat per cycle while out_tready is high and the frame store is not clearing.
// Reset (rst_n, synchronous, active low): the frame store is swept to zero, one word a cycle,
// through all 2*ROWS*(BYTES_PER_ROW/2) words (256 at the defaults); in_tready stays low meanwhile.
// Dwell registers reset to 100; the scan restarts at row 0, row select, red.

module led_matrix_scan_sequencer_unit #(
  parameter int ROWS          = 16,
  parameter int BYTES_PER_ROW = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input beats
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [lmss_pkg::IN_DATA_W-1:0]       in_tdata,  // row[3:0], column[7:4], pixel_byte[15:8]
  input  logic [lmss_pkg::IN_USER_W-1:0]       in_tuser,  // opcode[0], color[1]
  // Result beats
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // red_upper_n[0], red_lower_n[1], green_upper_n[2], green_lower_n[3], column_shift[4],
  // row_data[5], row_shift[6], latch[7], enable[8], zero[15:9]
  output logic [lmss_pkg::OUT_DATA_W-1:0]      out_tdata,
  // Configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lmss_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lmss_pkg::DWELL_W-1:0]         cfg_data
);

  localparam int HALF  = BYTES_PER_ROW / 2;
  localparam int DEPTH = 2 * ROWS * HALF;
  localparam int AW    = $clog2(DEPTH);

  // Input field split
  logic                                  in_opcode;
  logic                                  in_color;
  logic [lmss_pkg::ROW_IN_W-1:0]         in_row;
  logic [lmss_pkg::COL_IN_W-1:0]         in_column;
  logic [lmss_pkg::BYTE_W-1:0]           in_pixel_byte;

  assign in_opcode     = in_tuser[0];
  assign in_color      = in_tuser[1];
  assign in_row        = in_tdata[3:0];
  assign in_column     = in_tdata[7:4];
  assign in_pixel_byte = in_tdata[15:8];

  logic                                  accept;
  logic                                  is_tick;
  logic                                  wr_hit;
  logic                                  wr_lower;
  logic [AW-1:0]                         wr_addr;
  logic                                  clearing;
  lmss_pkg::tick_t                       tick_info;
  lmss_pkg::tick_t                       hold_info;
  logic                                  dwell_active;
  logic [AW-1:0]                         rd_addr;
  logic [lmss_pkg::BYTE_W-1:0]           rd_upper;
  logic [lmss_pkg::BYTE_W-1:0]           rd_lower;

  // Stage 1: beat in flight while the frame store read completes
  logic                                  s1_valid_r, s1_valid_nxt;
  lmss_pkg::tick_t                       s1_info_r;
  logic                                  s1_move;

  // Output register
  logic                                  out_valid_r, out_valid_nxt;
  logic [lmss_pkg::OUT_DATA_W-1:0]       out_data_r;
  logic [lmss_pkg::OUT_FIELDS-1:0]       pins;
  logic                                  up_bit;
  logic                                  lo_bit;

  assign cfg_ready = 1'b1;

  // Stage 1 advances into the output register when that is free or being drained
  assign s1_move   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !clearing && (!s1_valid_r || s1_move);
  assign accept    = in_tvalid && in_tready;
  assign is_tick   = (in_opcode == lmss_pkg::OP_TICK);

  // Write decode: drop rows and columns outside the frame
  assign wr_hit   = (32'(in_row) < ROWS) && (32'(in_column) < 2 * HALF);
  assign wr_lower = (32'(in_column) >= HALF);
  assign wr_addr  = AW'((int'(in_color) * ROWS + int'(in_row)) * HALF
                        + (wr_lower ? int'(in_column) - HALF : int'(in_column)));

  lmss_scan_ctrl #(
    .ROWS          (ROWS),
    .BYTES_PER_ROW (BYTES_PER_ROW),
    .AW            (AW)
  ) u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .tick         (accept && is_tick),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_idx      (cfg_index),
    .cfg_wdata    (cfg_data),
    .info         (tick_info),
    .dwell_active (dwell_active),
    .rd_addr      (rd_addr)
  );

  // Writes land at the accept edge, so any later tick reads the new byte
  lmss_frame_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (accept && !is_tick && wr_hit),
    .wr_lower (wr_lower),
    .wr_addr  (wr_addr),
    .wr_data  (in_pixel_byte),
    .rd_en    (accept && is_tick),
    .rd_addr  (rd_addr),
    .rd_upper (rd_upper),
    .rd_lower (rd_lower),
    .clearing (clearing)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold pattern for a write beat: only enable reflects a dwell in progress
  always_comb begin
    hold_info        = '0;
    hold_info.enable = dwell_active;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (is_tick) begin
        s1_info_r <= tick_info;
      end else begin
        s1_info_r <= hold_info;
      end
    end
  end

  // Pick the shifted bit and drive the active colour's lines low for lit LEDs
  always_comb begin
    up_bit  = rd_upper[s1_info_r.bit_sel];
    lo_bit  = rd_lower[s1_info_r.bit_sel];
    pins[0] = !(s1_info_r.shift && (s1_info_r.color == lmss_pkg::COLOR_RED) && up_bit);
    pins[1] = !(s1_info_r.shift && (s1_info_r.color == lmss_pkg::COLOR_RED) && lo_bit);
    pins[2] = !(s1_info_r.shift && (s1_info_r.color == lmss_pkg::COLOR_GREEN) && up_bit);
    pins[3] = !(s1_info_r.shift && (s1_info_r.color == lmss_pkg::COLOR_GREEN) && lo_bit);
    pins[4] = s1_info_r.column_shift;
    pins[5] = s1_info_r.row_data;
    pins[6] = s1_info_r.row_shift;
    pins[7] = s1_info_r.latch;
    pins[8] = s1_info_r.enable;
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data_r <= lmss_pkg::OUT_DATA_W'(pins);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
